[design/pcfk_pkg.sv]
// Shared constants and types for the planar chain forward kinematics core.
package pcfk_pkg;

   // Defaults for the core's parameters
   localparam int ANGLE_BITS_DEF     = 16;
   localparam int POS_BITS_DEF       = 24;
   localparam int ROTATION_STEPS_DEF = 16;

   // Fixed field widths of the words
   localparam int ANGLE_W  = 16;
   localparam int LEN_W    = 16;
   localparam int RADIUS_W = 16;
   localparam int COORD_W  = 24;

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_BASE_X       = 2'd0,
      REG_BASE_Y       = 2'd1,
      REG_BASE_HEADING = 2'd2
   } reg_index_type;

   // CORDIC datapath: vector keeps 14 fraction bits beyond Q8.8
   localparam int          VEC_W        = 32;
   localparam int          VEC_GUARD    = 14;
   localparam int          DELTA_W      = VEC_W - VEC_GUARD;
   localparam int          KINV_W       = 30;
   localparam logic [29:0] KINV_Q30     = 30'd652032875;
   localparam int          ATAN_ENTRIES = 24;

   // arctangent of 2^-i as a 32 bit fraction of a turn
   localparam logic [31:0] ATAN_TURN32 [ATAN_ENTRIES] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   // Fields that ride along the pipeline untouched
   typedef struct packed {
      logic [RADIUS_W-1:0] radius;
      logic                last;
      logic                first;
   } side_type;

endpackage

[design/pcfk_req_if.sv]
// Joint word channel: valid/ready handshake with joint payload.
interface pcfk_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [pcfk_pkg::ANGLE_W-1:0]    joint_angle;
   logic        [pcfk_pkg::LEN_W-1:0]      link_length;
   logic        [pcfk_pkg::RADIUS_W-1:0]   link_radius;
   logic                                   last;

   modport source (output valid, output joint_angle, output link_length,
                   output link_radius, output last, input ready);
   modport sink   (input valid, input joint_angle, input link_length,
                   input link_radius, input last, output ready);
endinterface

[design/pcfk_rsp_if.sv]
// Capsule word channel: valid/ready handshake with capsule payload.
interface pcfk_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [pcfk_pkg::COORD_W-1:0]    start_x;
   logic signed [pcfk_pkg::COORD_W-1:0]    start_y;
   logic signed [pcfk_pkg::COORD_W-1:0]    end_x;
   logic signed [pcfk_pkg::COORD_W-1:0]    end_y;
   logic        [pcfk_pkg::RADIUS_W-1:0]   radius;
   logic                                   final_segment;

   modport source (output valid, output start_x, output start_y, output end_x,
                   output end_y, output radius, output final_segment, input ready);
   modport sink   (input valid, input start_x, input start_y, input end_x,
                   input end_y, input radius, input final_segment, output ready);
endinterface

[design/planar_chain_forward_kinematics_core.sv]
// Planar chain forward kinematics core: heading, CORDIC pipeline, tip accumulation.
// Stages: the edge that accepts a joint word loads the heading stage, then come the pre-rotation
//   stage, one stage per CORDIC step (steps capped at 24), the rounding stage and the output
//   register, which drives capsule word valid.
// Throughput: one joint word per cycle while the pipeline is not full; every stage has its
//   own valid bit and bubbles collapse, so a waiting capsule does not stop it until it is full.
// Reset: synchronous; clears valid bits, base pose registers, heading and tip, and
//   marks the next joint as a chain start.
module planar_chain_forward_kinematics_core #(
   parameter int ANGLE_BITS     = pcfk_pkg::ANGLE_BITS_DEF,
   parameter int POS_BITS       = pcfk_pkg::POS_BITS_DEF,
   parameter int ROTATION_STEPS = pcfk_pkg::ROTATION_STEPS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   pcfk_req_if.sink                          req_bus,
   pcfk_rsp_if.source                        rsp_bus,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pcfk_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [pcfk_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [pcfk_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int NUM_STEPS = (ROTATION_STEPS < pcfk_pkg::ATAN_ENTRIES) ?
                              ROTATION_STEPS : pcfk_pkg::ATAN_ENTRIES;
   localparam int PIPE_D    = NUM_STEPS + 3;
   localparam int VW        = pcfk_pkg::VEC_W;
   localparam int DW        = pcfk_pkg::DELTA_W;
   localparam int CW        = pcfk_pkg::COORD_W;
   localparam int SUM_W     = ((POS_BITS > CW) ? POS_BITS : CW) + 2;
   localparam int PROD_W    = pcfk_pkg::LEN_W + pcfk_pkg::KINV_W;
   localparam int ZPAD      = VW - ANGLE_BITS;

   localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'((64'sd1 <<< (POS_BITS - 1)) - 64'sd1);
   localparam logic signed [SUM_W-1:0] POS_MIN = -POS_MAX - SUM_W'(1);
   localparam logic signed [VW-1:0]    ROUND_HALF = VW'(64'sd1 <<< (pcfk_pkg::VEC_GUARD - 1));

   function automatic logic [ANGLE_BITS-1:0] to_heading(input logic [pcfk_pkg::ANGLE_W-1:0] a);
      logic [ANGLE_BITS+pcfk_pkg::ANGLE_W-1:0] wide;
      wide = {a, {ANGLE_BITS{1'b0}}};
      return wide[ANGLE_BITS+pcfk_pkg::ANGLE_W-1:pcfk_pkg::ANGLE_W];
   endfunction

   function automatic logic signed [SUM_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
      if (v > POS_MAX) return POS_MAX;
      if (v < POS_MIN) return POS_MIN;
      return v;
   endfunction

   // ---------------- configuration registers ----------------
   logic signed [CW-1:0]                  base_x_ff, base_y_ff;
   logic signed [pcfk_pkg::ANGLE_W-1:0]   base_heading_ff;
   logic                                  csr_write;
   pcfk_pkg::reg_index_type               csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = pcfk_pkg::reg_index_type'(csr_paddr[pcfk_pkg::CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_x_ff       <= '0;
         base_y_ff       <= '0;
         base_heading_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            pcfk_pkg::REG_BASE_X:       base_x_ff       <= csr_pwdata[CW-1:0];
            pcfk_pkg::REG_BASE_Y:       base_y_ff       <= csr_pwdata[CW-1:0];
            pcfk_pkg::REG_BASE_HEADING: base_heading_ff <= csr_pwdata[pcfk_pkg::ANGLE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         pcfk_pkg::REG_BASE_X:       csr_prdata = pcfk_pkg::CSR_DATA_W'(unsigned'(base_x_ff));
         pcfk_pkg::REG_BASE_Y:       csr_prdata = pcfk_pkg::CSR_DATA_W'(unsigned'(base_y_ff));
         pcfk_pkg::REG_BASE_HEADING:
            csr_prdata = pcfk_pkg::CSR_DATA_W'(unsigned'(base_heading_ff));
         default:                    csr_prdata = '0;
      endcase
   end

   // ---------------- pipeline handshake ----------------
   logic                 pipe_v_ff [PIPE_D];
   logic                 pipe_rdy  [PIPE_D+1];
   pcfk_pkg::side_type   side_ff   [PIPE_D];
   logic                 req_fire, out_load;

   assign pipe_rdy[PIPE_D] = !rsp_bus.valid || rsp_bus.ready;
   for (genvar k = 0; k < PIPE_D; k++) begin : g_hs
      assign pipe_rdy[k] = !pipe_v_ff[k] || pipe_rdy[k+1];
      always_ff @(posedge clock) begin
         if (reset) begin
            pipe_v_ff[k] <= 1'b0;
         end else if (pipe_rdy[k]) begin
            pipe_v_ff[k] <= (k == 0) ? req_bus.valid : pipe_v_ff[(k == 0) ? 0 : k-1];
         end
      end
      if (k > 0) begin : g_side
         always_ff @(posedge clock) begin
            if (pipe_rdy[k]) side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign req_bus.ready = pipe_rdy[0];
   assign req_fire      = req_bus.valid && pipe_rdy[0];
   assign out_load      = pipe_v_ff[PIPE_D-1] && pipe_rdy[PIPE_D];

   // ---------------- stage 0: running heading ----------------
   logic [ANGLE_BITS-1:0]         heading_ff, heading_in;
   logic                          chain_start_ff;
   logic [ANGLE_BITS-1:0]         hd0_ff;
   logic [pcfk_pkg::LEN_W-1:0]    len0_ff;

   assign heading_in = (chain_start_ff ? to_heading(base_heading_ff) : heading_ff) +
                       to_heading(req_bus.joint_angle);

   always_ff @(posedge clock) begin
      if (reset) begin
         heading_ff     <= '0;
         chain_start_ff <= 1'b1;
      end else if (req_fire) begin
         heading_ff     <= heading_in;
         chain_start_ff <= req_bus.last;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_rdy[0]) begin
         hd0_ff        <= heading_in;
         len0_ff       <= req_bus.link_length;
         side_ff[0]    <= '{radius: req_bus.link_radius, last: req_bus.last,
                            first: chain_start_ff};
      end
   end

   // ---------------- stage 1: start vector and quadrant fold ----------------
   logic signed [VW-1:0] x_ff [NUM_STEPS+1];
   logic signed [VW-1:0] y_ff [NUM_STEPS+1];
   logic        [VW-1:0] z_ff [NUM_STEPS];
   logic [PROD_W-1:0]    len_prod;
   logic signed [VW-1:0] x0_in;
   logic [VW-1:0]        z0_raw;

   assign len_prod = PROD_W'(len0_ff) * PROD_W'(pcfk_pkg::KINV_Q30);
   assign x0_in    = VW'(len_prod[PROD_W-1:pcfk_pkg::LEN_W]);
   assign z0_raw   = {hd0_ff, {ZPAD{1'b0}}};

   always_ff @(posedge clock) begin
      if (pipe_rdy[1]) begin
         // heading in the left half plane: start from -x and turn half a turn back
         if (z0_raw[VW-1] != z0_raw[VW-2]) begin
            x_ff[0] <= -x0_in;
            z_ff[0] <= {~z0_raw[VW-1], z0_raw[VW-2:0]};
         end else begin
            x_ff[0] <= x0_in;
            z_ff[0] <= z0_raw;
         end
         y_ff[0] <= '0;
      end
   end

   // ---------------- CORDIC steps, one per stage ----------------
   for (genvar j = 0; j < NUM_STEPS; j++) begin : g_step
      logic signed [VW-1:0] xs, ys;
      assign xs = x_ff[j] >>> j;
      assign ys = y_ff[j] >>> j;
      always_ff @(posedge clock) begin
         if (pipe_rdy[j+2]) begin
            if (z_ff[j][VW-1]) begin
               x_ff[j+1] <= x_ff[j] + ys;
               y_ff[j+1] <= y_ff[j] - xs;
            end else begin
               x_ff[j+1] <= x_ff[j] - ys;
               y_ff[j+1] <= y_ff[j] + xs;
            end
         end
      end
      if (j + 1 < NUM_STEPS) begin : g_z
         always_ff @(posedge clock) begin
            if (pipe_rdy[j+2]) begin
               z_ff[j+1] <= z_ff[j][VW-1] ? z_ff[j] + pcfk_pkg::ATAN_TURN32[j]
                                          : z_ff[j] - pcfk_pkg::ATAN_TURN32[j];
            end
         end
      end
   end

   // ---------------- rounding to Q8.8 ----------------
   logic signed [VW-1:0] xr, yr;
   logic signed [DW-1:0] dx_ff, dy_ff;

   assign xr = x_ff[NUM_STEPS] + ROUND_HALF;
   assign yr = y_ff[NUM_STEPS] + ROUND_HALF;

   always_ff @(posedge clock) begin
      if (pipe_rdy[PIPE_D-1]) begin
         dx_ff <= xr[VW-1:pcfk_pkg::VEC_GUARD];
         dy_ff <= yr[VW-1:pcfk_pkg::VEC_GUARD];
      end
   end

   // ---------------- tip accumulation and capsule register ----------------
   logic signed [POS_BITS-1:0] tip_x_ff, tip_y_ff;
   logic signed [SUM_W-1:0]    start_x_w, start_y_w, end_x_w, end_y_w;
   logic                       rsp_valid_ff;
   logic signed [CW-1:0]       start_x_ff, start_y_ff, end_x_ff, end_y_ff;
   pcfk_pkg::side_type         out_side_ff;

   assign start_x_w = side_ff[PIPE_D-1].first ? sat_pos(SUM_W'(base_x_ff)) : SUM_W'(tip_x_ff);
   assign start_y_w = side_ff[PIPE_D-1].first ? sat_pos(SUM_W'(base_y_ff)) : SUM_W'(tip_y_ff);
   assign end_x_w   = sat_pos(start_x_w + SUM_W'(dx_ff));
   assign end_y_w   = sat_pos(start_y_w + SUM_W'(dy_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         tip_x_ff     <= '0;
         tip_y_ff     <= '0;
      end else begin
         if (pipe_rdy[PIPE_D]) rsp_valid_ff <= pipe_v_ff[PIPE_D-1];
         if (out_load) begin
            tip_x_ff <= end_x_w[POS_BITS-1:0];
            tip_y_ff <= end_y_w[POS_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_rdy[PIPE_D]) begin
         start_x_ff  <= start_x_w[CW-1:0];
         start_y_ff  <= start_y_w[CW-1:0];
         end_x_ff    <= end_x_w[CW-1:0];
         end_y_ff    <= end_y_w[CW-1:0];
         out_side_ff <= side_ff[PIPE_D-1];
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.start_x       = start_x_ff;
   assign rsp_bus.start_y       = start_y_ff;
   assign rsp_bus.end_x         = end_x_ff;
   assign rsp_bus.end_y         = end_y_ff;
   assign rsp_bus.radius        = out_side_ff.radius;
   assign rsp_bus.final_segment = out_side_ff.last;

   // ---------------- assertions ----------------
   a_tip_hold: assert property (@(posedge clock) disable iff (reset)
      !out_load |=> $stable(tip_x_ff) && $stable(tip_y_ff))
      else $error("tip moved without a capsule word entering the output register");

   a_heading_hold: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(heading_ff) && $stable(chain_start_ff))
      else $error("heading changed without a joint word accepted");

   a_tail_kept: assert property (@(posedge clock) disable iff (reset)
      pipe_v_ff[PIPE_D-1] && !pipe_rdy[PIPE_D] |=> pipe_v_ff[PIPE_D-1])
      else $error("word in the last stage dropped while output stalled");

   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_bus.valid)
      else $error("capsule word loaded but not presented");

endmodule

[sim/tb_planar_chain_forward_kinematics_core.sv]
// Testbench for the planar chain forward kinematics core: predicted capsules checked per word.
module tb_planar_chain_forward_kinematics_core;

   localparam int     ANGLE_W       = pcfk_pkg::ANGLE_W;
   localparam int     LEN_W         = pcfk_pkg::LEN_W;
   localparam int     RADIUS_W      = pcfk_pkg::RADIUS_W;
   localparam int     COORD_W       = pcfk_pkg::COORD_W;
   localparam int     CSR_ADDR_W    = pcfk_pkg::CSR_ADDR_W;
   localparam int     CSR_DATA_W    = pcfk_pkg::CSR_DATA_W;
   localparam int     ATAN_ENTRIES  = pcfk_pkg::ATAN_ENTRIES;
   localparam int     VEC_GUARD     = pcfk_pkg::VEC_GUARD;
   localparam int     HEAD_BITS     = pcfk_pkg::ANGLE_BITS_DEF;
   localparam int     TIP_BITS      = pcfk_pkg::POS_BITS_DEF;
   localparam int     CORDIC_STEPS  = pcfk_pkg::ROTATION_STEPS_DEF;
   localparam int     PIPE_LATENCY  = CORDIC_STEPS + 3;
   localparam int     DRAIN_CYCLES  = 2 * PIPE_LATENCY + 10;
   localparam int     CYCLE_LIMIT   = 400000;
   localparam int     RANDOM_JOINTS = 1550;
   localparam int     RANDOM_PHASES = 4;
   localparam int     MAX_REPORTS   = 40;
   localparam longint TIP_MAX       = (longint'(1) <<< (TIP_BITS - 1)) - 1;
   localparam longint TIP_MIN       = -TIP_MAX - 1;

   localparam logic [1:0]  REG_UNMAPPED = 2'd3;
   localparam logic [15:0] ANGLE_ZERO   = 16'h0000;
   localparam logic [15:0] QUARTER_TURN = 16'h4000;
   localparam logic [15:0] HALF_TURN    = 16'h8000;
   localparam logic [15:0] MINUS_QUARTER = 16'hC000;
   localparam logic [15:0] ANGLE_MAX    = 16'h7FFF;
   localparam logic [15:0] LEN_MAX      = 16'hFFFF;
   localparam logic [23:0] COORD_MAX    = 24'h7FFFFF;
   localparam logic [23:0] COORD_MIN    = 24'h800000;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] joint_angle;
      logic [LEN_W-1:0]          link_length;
      logic [RADIUS_W-1:0]       link_radius;
      logic                      last;
   } joint_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      logic [RADIUS_W-1:0]       radius;
      logic                      final_segment;
   } capsule_type;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata, csr_prdata;

   pcfk_req_if req_bus ();
   pcfk_rsp_if rsp_bus ();

   planar_chain_forward_kinematics_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // arm state as the core should hold it
   logic signed [COORD_W-1:0] base_x_q, base_y_q;
   logic [ANGLE_W-1:0]        base_heading_q;
   logic [HEAD_BITS-1:0]      arm_heading;
   longint                    tip_x, tip_y;
   bit                        chain_open;

   capsule_type capsules_due[$];

   int send_idle_pct;
   int recv_stall_pct;
   int mismatches = 0;
   int joints_sent;
   int capsules_seen = 0;
   int chains_closed;
   int clamped_tips;
   int cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d capsules outstanding", cycle_count,
                  capsules_due.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);

   function automatic logic [HEAD_BITS-1:0] to_heading(input logic [ANGLE_W-1:0] a);
      logic [31:0] w;
      w = {16'b0, a};
      if (HEAD_BITS >= ANGLE_W) w = w << (HEAD_BITS - ANGLE_W);
      else w = w >> (ANGLE_W - HEAD_BITS);
      return w[HEAD_BITS-1:0];
   endfunction

   function automatic longint clamp_tip(input longint v);
      if (v > TIP_MAX) return TIP_MAX;
      if (v < TIP_MIN) return TIP_MIN;
      return v;
   endfunction

   // CORDIC rotation of (len * Kinv, 0) by the heading, rounded back to Q8.8
   function automatic void rotate_link(input logic [HEAD_BITS-1:0] hd,
                                       input logic [LEN_W-1:0] len,
                                       output longint dx, output longint dy);
      logic [31:0] z;
      longint      x, y, xs, ys;
      int          i;
      z = 32'(hd) << (32 - HEAD_BITS);
      x = (longint'(len) * longint'(pcfk_pkg::KINV_Q30)) >>> 16;
      y = 0;
      // second and third quadrant: flip the vector and take half a turn off
      if (z[31] != z[30]) begin
         x = -x;
         z = z + 32'h8000_0000;
      end
      for (i = 0; i < CORDIC_STEPS && i < ATAN_ENTRIES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z[31]) begin
            x = x + ys;
            y = y - xs;
            z = z + pcfk_pkg::ATAN_TURN32[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - pcfk_pkg::ATAN_TURN32[i];
         end
      end
      dx = (x + (longint'(1) <<< (VEC_GUARD - 1))) >>> VEC_GUARD;
      dy = (y + (longint'(1) <<< (VEC_GUARD - 1))) >>> VEC_GUARD;
   endfunction

   function automatic capsule_type next_capsule(input joint_type j);
      capsule_type c;
      longint      dx, dy;
      // base pose is picked up only when a chain begins
      if (!chain_open) begin
         arm_heading = to_heading(base_heading_q);
         tip_x = clamp_tip(longint'(base_x_q));
         tip_y = clamp_tip(longint'(base_y_q));
      end
      arm_heading = arm_heading + to_heading(j.joint_angle);
      rotate_link(arm_heading, j.link_length, dx, dy);
      c.start_x = tip_x[COORD_W-1:0];
      c.start_y = tip_y[COORD_W-1:0];
      tip_x = clamp_tip(tip_x + dx);
      tip_y = clamp_tip(tip_y + dy);
      if (tip_x == TIP_MAX || tip_x == TIP_MIN || tip_y == TIP_MAX || tip_y == TIP_MIN)
         clamped_tips++;
      c.end_x = tip_x[COORD_W-1:0];
      c.end_y = tip_y[COORD_W-1:0];
      c.radius = j.link_radius;
      c.final_segment = j.last;
      chain_open = !j.last;
      if (j.last) chains_closed++;
      return c;
   endfunction

   function automatic void check_field(input string name, input longint want,
                                       input longint got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: capsule %0d %s mismatch: expected %h, got %h", $time,
                     capsules_seen, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      capsule_type due;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (capsules_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected capsule: expected none, got %h %h %h %h", $time,
                        rsp_bus.start_x, rsp_bus.start_y, rsp_bus.end_x, rsp_bus.end_y);
         end else begin
            due = capsules_due.pop_front();
            check_field("start_x", due.start_x, rsp_bus.start_x);
            check_field("start_y", due.start_y, rsp_bus.start_y);
            check_field("end_x", due.end_x, rsp_bus.end_x);
            check_field("end_y", due.end_y, rsp_bus.end_y);
            check_field("radius", due.radius, rsp_bus.radius);
            check_field("final_segment", due.final_segment, rsp_bus.final_segment);
         end
         capsules_seen++;
      end
   end

   function automatic joint_type joint_word(input logic [15:0] angle, input logic [15:0] len,
                                            input logic [15:0] radius, input bit last);
      joint_type j;
      j.joint_angle = angle;
      j.link_length = len;
      j.link_radius = radius;
      j.last = last;
      return j;
   endfunction

   // valid stays high from one word to the next unless an idle cycle falls between
   task automatic send_joint(input joint_type j);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.joint_angle <= j.joint_angle;
      req_bus.link_length <= j.link_length;
      req_bus.link_radius <= j.link_radius;
      req_bus.last        <= j.last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      capsules_due.push_back(next_capsule(j));
      joints_sent++;
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (capsules_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // the bus goes idle after the access phase before the next transfer
   task automatic write_base_reg(input logic [1:0] idx, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         pcfk_pkg::REG_BASE_X:       base_x_q = data[COORD_W-1:0];
         pcfk_pkg::REG_BASE_Y:       base_y_q = data[COORD_W-1:0];
         pcfk_pkg::REG_BASE_HEADING: base_heading_q = data[ANGLE_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // upper bits beyond the register width carry noise
   task automatic set_base_pose(input logic [23:0] bx, input logic [23:0] by,
                                input logic [15:0] bh);
      write_base_reg(pcfk_pkg::REG_BASE_X, {8'($urandom), bx});
      write_base_reg(pcfk_pkg::REG_BASE_Y, {8'($urandom), by});
      write_base_reg(pcfk_pkg::REG_BASE_HEADING, {16'($urandom), bh});
   endtask

   task automatic test_home_pose();
      send_joint(joint_word(ANGLE_ZERO, LEN_MAX, 16'h0000, 1'b0));
      send_joint(joint_word(QUARTER_TURN, LEN_MAX, 16'hFFFF, 1'b0));
      send_joint(joint_word(HALF_TURN, 16'h0100, 16'h5A5A, 1'b0));
      send_joint(joint_word(ANGLE_MAX, 16'h0000, 16'hA5A5, 1'b0));
      send_joint(joint_word(16'h0001, 16'h8000, 16'h0080, 1'b0));
      send_joint(joint_word(16'hFFFF, 16'h0001, 16'h0001, 1'b1));
      send_joint(joint_word(MINUS_QUARTER, 16'h1234, 16'h00FF, 1'b1));
      wait_idle();
   endtask

   task automatic test_base_pose();
      set_base_pose(24'h012345, 24'hFEDCBA, 16'h2000);
      send_joint(joint_word(ANGLE_ZERO, 16'h0400, 16'h0100, 1'b0));
      send_joint(joint_word(16'hE000, 16'h0400, 16'h0200, 1'b1));
      send_joint(joint_word(16'h6000, 16'h0300, 16'h0300, 1'b1));
      wait_idle();
   endtask

   // tips pushed past both ends of the coordinate range on both axes
   task automatic test_position_saturation();
      set_base_pose(COORD_MAX, COORD_MIN, ANGLE_ZERO);
      send_joint(joint_word(ANGLE_ZERO, LEN_MAX, 16'h0010, 1'b0));
      send_joint(joint_word(QUARTER_TURN, LEN_MAX, 16'h0020, 1'b0));
      send_joint(joint_word(HALF_TURN, LEN_MAX, 16'h0030, 1'b1));
      wait_idle();
      set_base_pose(COORD_MIN, COORD_MAX, HALF_TURN);
      send_joint(joint_word(ANGLE_ZERO, LEN_MAX, 16'h0040, 1'b0));
      send_joint(joint_word(MINUS_QUARTER, LEN_MAX, 16'h0050, 1'b1));
      wait_idle();
   endtask

   // a base write in the middle of a chain must wait for the next chain
   task automatic test_deferred_base_update();
      set_base_pose(24'h000100, 24'h000200, ANGLE_ZERO);
      send_joint(joint_word(16'h1000, 16'h0800, 16'h0011, 1'b0));
      wait_idle();
      set_base_pose(24'h400000, 24'hC00000, QUARTER_TURN);
      send_joint(joint_word(16'h1000, 16'h0800, 16'h0022, 1'b1));
      send_joint(joint_word(16'h1000, 16'h0800, 16'h0033, 1'b1));
      wait_idle();
   endtask

   task automatic test_unmapped_register();
      write_base_reg(REG_UNMAPPED, $urandom);
      send_joint(joint_word(16'h3000, 16'h0200, 16'h0044, 1'b0));
      send_joint(joint_word(16'hD000, 16'h0200, 16'h0055, 1'b1));
      wait_idle();
   endtask

   function automatic joint_type random_joint(input bit last);
      logic [15:0] angle, len;
      case ($urandom_range(9))
         0: angle = QUARTER_TURN;
         1: angle = HALF_TURN;
         2: angle = MINUS_QUARTER;
         3: angle = 16'($urandom_range(64)) - 16'd32;
         default: angle = 16'($urandom);
      endcase
      case ($urandom_range(9))
         0: len = 16'h0000;
         1, 2: len = LEN_MAX;
         3, 4: len = 16'($urandom_range(1024));
         default: len = 16'($urandom);
      endcase
      return joint_word(angle, len, 16'($urandom), last);
   endfunction

   task automatic test_random_chains(input int phase, input int idle_pct, input int stall_pct);
      int sent;
      int links;
      int k;
      case (phase)
         0: set_base_pose(24'h000000, 24'h000000, ANGLE_ZERO);
         1: set_base_pose(COORD_MAX, COORD_MIN, ANGLE_MAX);
         2: set_base_pose(COORD_MIN, COORD_MAX, HALF_TURN);
         default: set_base_pose(24'($urandom), 24'($urandom), 16'($urandom));
      endcase
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      sent = 0;
      while (sent < RANDOM_JOINTS / RANDOM_PHASES) begin
         links = ($urandom_range(7) == 0) ? $urandom_range(60, 20) : $urandom_range(10, 1);
         for (k = 0; k < links; k++)
            send_joint(random_joint(k == links - 1));
         sent += links;
      end
      wait_idle();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.joint_angle = '0;
      req_bus.link_length = '0;
      req_bus.link_radius = '0;
      req_bus.last = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      base_x_q = '0;
      base_y_q = '0;
      base_heading_q = '0;
      arm_heading = '0;
      tip_x = 0;
      tip_y = 0;
      chain_open = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      joints_sent = 0;
      chains_closed = 0;
      clamped_tips = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_home_pose();
      test_base_pose();
      test_position_saturation();
      test_deferred_base_update();
      test_unmapped_register();
      test_random_chains(0, 0, 0);
      test_random_chains(1, 56, 0);
      test_random_chains(2, 0, 56);
      test_random_chains(3, 38, 38);

      $display("Ran %0d joint words in %0d closed chains; %0d capsules compared, %0d %s",
               joints_sent, chains_closed, capsules_seen, clamped_tips, "with a clamped tip.");
      $display("Base pose covered zero, both range ends and random values under four idle mixes.");
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
